// ----- rtl/sinusoidal_position_encode_core_defines.svh -----
// assertion macros shared by the checker of the position encoder
// needs clk and rst_n in the scope where a macro is used
`ifndef SINUSOIDAL_POSITION_ENCODE_CORE_DEFINES_SVH
`define SINUSOIDAL_POSITION_ENCODE_CORE_DEFINES_SVH

// property that is checked only outside reset
`define SPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that is checked during reset too
`define SPE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/spe_pkg.sv -----
// constants, tables and types of the sinusoidal position encoder
// used by spe_step and sinusoidal_position_encode_core
package spe_pkg;

  localparam int MAX_DIM_DEF      = 4096;
  localparam int CORDIC_STEPS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  localparam logic [15:0] BASE_RST = 16'd10000;
  localparam logic [12:0] ROWS_RST = 13'd64;
  localparam logic [12:0] COLS_RST = 13'd64;

  localparam logic [31:0] ONE_RAD_TURNS = 32'd683565276;
  localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;

  // log2 of the base in q16.16 is below 2^20
  localparam int LOG_W     = 20;
  localparam int EXP_STEPS = 16;

  typedef logic [31:0] atan_tab_t [32];
  typedef logic [31:0] root_tab_t [EXP_STEPS];

  localparam atan_tab_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // 2^-(2^-(k+1)) in q0.32, each a floor square root of the one before
  function automatic root_tab_t gen_roots();
    root_tab_t   tab;
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    r = 64'd1 << 31;
    for (int k = 0; k < EXP_STEPS; k++) begin
      n   = r << 32;
      res = 64'd0;
      b   = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 64'd0) begin
        if (n >= res + b) begin
          n   = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      r      = res;
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t EXP_ROOT = gen_roots();

  typedef struct packed {
    logic        done;
    logic [31:0] step;
  } step_resp_t;

endpackage

// ----- rtl/spe_step.sv -----
// per-column phase step: log2 of base, exponent divide, 2^-frac product
// iterates on one shared multiplier and a bit-serial divider; uses spe_pkg
module spe_step #(
  parameter int MAX_DIM = spe_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [15:0]                       base,
  input  logic [$clog2(MAX_DIM+1)-1:0]      cols_cl,
  input  logic [$clog2(MAX_DIM)-1:0]        col,
  output spe_pkg::step_resp_t               resp
);
  import spe_pkg::*;

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CW   = $clog2(MAX_DIM);
  localparam int NW   = LOG_W + CW;
  localparam int CNTW = $clog2(NW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQR   = 3'd1;
  localparam logic [2:0] S_MULE  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EXP   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [31:0]      x_r, x_nxt;
  logic [LOG_W-1:0] lg_r, lg_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [DW-1:0]    cd_r, cd_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    num_r, num_nxt;
  logic [32:0]      m_r, m_nxt;
  logic [31:0]      s_r, s_nxt;
  logic [31:0]      step_r, step_nxt;
  logic             done_r, done_nxt;

  logic [32:0]      mul_a;
  logic [31:0]      mul_b;
  logic [64:0]      prod;
  logic [3:0]       lead;
  logic [32:0]      sq;
  logic [DW:0]      trial;
  logic             ge;
  logic [NW-17:0]   ip;

  always_comb begin
    lead = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (base[i]) lead = 4'(i);
    end
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_SQR:   begin mul_a = {1'b0, x_r};          mul_b = x_r; end
      S_MULE:  begin mul_a = 33'(lg_r);            mul_b = 32'(col_r); end
      S_EXP:   begin mul_a = m_r;                  mul_b = EXP_ROOT[cnt_r[3:0]]; end
      S_SCALE: begin mul_a = m_r;                  mul_b = ONE_RAD_TURNS; end
      default: begin mul_a = 33'd0;                mul_b = 32'd0; end
    endcase
    prod = 65'(mul_a) * 65'(mul_b);
  end

  assign sq    = prod[63:31];
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, cd_r};
  assign ip    = num_r[NW-1:16];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    lg_nxt    = lg_r;
    col_nxt   = col_r;
    cd_nxt    = cd_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    m_nxt     = m_r;
    s_nxt     = s_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          col_nxt = col;
          cd_nxt  = cols_cl;
          cnt_nxt = '0;
          x_nxt   = 32'(base) << (5'd31 - 5'(lead));
          lg_nxt  = LOG_W'({lead, 16'd0});
          if (base < 16'd2) begin
            lg_nxt    = '0;
            state_nxt = S_MULE;
          end else begin
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        // one fraction bit of log2 per squaring
        if (sq[32]) begin
          x_nxt  = sq[32:1];
          lg_nxt = lg_r | LOG_W'(32'd1 << (5'd15 - 5'(cnt_r)));
        end else begin
          x_nxt = sq[31:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(EXP_STEPS - 1)) state_nxt = S_MULE;
      end
      S_MULE: begin
        num_nxt   = prod[NW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? DW'(trial - {1'b0, cd_r}) : trial[DW-1:0];
        num_nxt = {num_r[NW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          cnt_nxt   = '0;
          m_nxt     = 33'h1_0000_0000;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (num_r[5'd15 - 5'(cnt_r)]) m_nxt = prod[64:32];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(EXP_STEPS - 1)) state_nxt = S_SCALE;
      end
      S_SCALE: begin
        s_nxt     = prod[63:32];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        step_nxt  = (32'(ip) >= 32'd32) ? 32'd0 : (s_r >> ip[4:0]);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r    <= x_nxt;
    lg_r   <= lg_nxt;
    col_r  <= col_nxt;
    cd_r   <= cd_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    m_r    <= m_nxt;
    s_r    <= s_nxt;
    step_r <= step_nxt;
  end

  assign resp.done = done_r;
  assign resp.step = step_r;

endmodule

// ----- rtl/sinusoidal_position_encode_core.sv -----
// Sinusoidal position encoder: each beat of in_tdata (q16.16, column-major
// matrix order) gets sin(row / base^(col/cols)) added and is clipped to q16.16.
// An element is accepted, takes CORDIC_STEPS rotation steps of the shared
// cordic datapath, one per cycle, and is then loaded into the output register
// once a pending result has been taken; after an element that ends a column,
// unless it is a last_element one, the next element waits while spe_step runs
// its 16 log2 squarings, the bit-serial exponent divide, the 16 2^-frac
// products and the final scale on its one multiplier (no squarings when base is below two).
// in_tready is high only between elements. cfg_ready is always high.
module sinusoidal_position_encode_core #(
  parameter int MAX_DIM      = spe_pkg::MAX_DIM_DEF,
  parameter int CORDIC_STEPS = spe_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] in_value
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] out_value
  output logic        out_tuser,  // [0] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import spe_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);
  localparam int IW = $clog2(CORDIC_STEPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  localparam logic [1:0] S_STEP = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [15:0]        base_r;
  logic [12:0]        rows_r, cols_r;
  logic [CW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [31:0]        phase_r, phase_nxt;
  logic [31:0]        step_r, step_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [IW-1:0]      it_r, it_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [31:0]        val_r, val_nxt;
  logic               last_r, last_nxt;
  logic               ov_r, ov_nxt;
  logic [31:0]        od_r, od_nxt;
  logic               os_r, os_nxt;
  logic               start;

  logic [DW-1:0]      rows_cl, cols_cl;
  logic [CW-1:0]      col_adv;
  logic signed [33:0] dx, dy, atn, v_sel, v_sh, v_fin;
  logic signed [34:0] sum;
  step_resp_t         sresp;

  function automatic logic [DW-1:0] clamp_dim(logic [12:0] d);
    if (d == 13'd0) return DW'(1);
    if (32'(d) > 32'(MAX_DIM)) return DW'(MAX_DIM);
    return DW'(d);
  endfunction

  assign rows_cl = clamp_dim(rows_r);
  assign cols_cl = clamp_dim(cols_r);
  assign col_adv = (32'(col_r) + 32'd1 >= 32'(cols_cl)) ? '0 : col_r + 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;

  // cordic rotation step
  assign dx  = y_r >>> it_r;
  assign dy  = x_r >>> it_r;
  assign atn = $signed({2'b00, ATAN_TURNS[5'(it_r)]});

  // q1.30 to q16.16 with rounding, then the exact sum
  assign v_sel = quad_r[0] ? x_r : y_r;
  assign v_sh  = (v_sel + 34'sd8192) >>> 14;
  assign v_fin = quad_r[1] ? -v_sh : v_sh;
  assign sum   = $signed({{3{val_r[31]}}, val_r}) + $signed({v_fin[33], v_fin});

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    it_nxt    = it_r;
    quad_nxt  = quad_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    os_nxt    = os_r;
    start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_tdata;
          last_nxt  = in_tlast;
          quad_nxt  = phase_r[31:30];
          z_nxt     = $signed({4'b0000, phase_r[29:0]});
          x_nxt     = $signed(CORDIC_GAIN);
          y_nxt     = '0;
          it_nxt    = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atn;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atn;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IW'(CORDIC_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          os_nxt = 1'b0;
          od_nxt = sum[31:0];
          if (sum > 35'sh0_7FFF_FFFF) begin
            od_nxt = 32'h7FFF_FFFF;
            os_nxt = 1'b1;
          end else if (sum < -35'sh0_8000_0000) begin
            od_nxt = 32'h8000_0000;
            os_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
          if (last_r) begin
            row_nxt   = '0;
            col_nxt   = '0;
            phase_nxt = '0;
            step_nxt  = ONE_RAD_TURNS;
          end else if (32'(row_r) + 32'd1 >= 32'(rows_cl)) begin
            row_nxt   = '0;
            col_nxt   = col_adv;
            phase_nxt = '0;
            start     = 1'b1;
            state_nxt = S_STEP;
          end else begin
            row_nxt   = row_r + 1'b1;
            phase_nxt = phase_r + step_r;
          end
        end
      end
      S_STEP: begin
        if (sresp.done) begin
          step_nxt  = sresp.step;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= BASE_RST;
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= '0;
      step_r  <= ONE_RAD_TURNS;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE: base_r <= cfg_data;
          CFG_ROWS: rows_r <= cfg_data[12:0];
          CFG_COLS: cols_r <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    it_r   <= it_nxt;
    quad_r <= quad_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
  end

  spe_step #(
    .MAX_DIM(MAX_DIM)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .base    (base_r),
    .cols_cl (cols_cl),
    .col     (col_nxt),
    .resp    (sresp)
  );

endmodule

// ----- rtl/spe_port_check.sv -----
// port-level checks of the position encoder, bound to the top level
// uses the macros of sinusoidal_position_encode_core_defines.svh
`include "sinusoidal_position_encode_core_defines.svh"

module spe_port_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result beat stays offered
  `SPE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")

  // the rotation keeps the block busy right after an accepted beat
  `SPE_ASSERT(a_busy_after_in, in_tvalid && in_tready |=> !in_tready, "ready during work")

  // a clipped result is one of the two range limits
  `SPE_ASSERT(a_sat_limit,
    out_tvalid && out_tuser |-> (out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000),
    "saturated flag without limit value")

  // reset leaves no result pending
  `SPE_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sinusoidal_position_encode_core spe_port_check u_port_check (.*);
